// ===== sv/kmc_pkg.sv =====
// Shared constants and types for the k-mer minimizer counter.
package kmc_pkg;

	localparam int HASH_BITS  = 20;
	localparam int MAX_WINDOW = 16;
	localparam int CNT_W      = 32;
	localparam int KLEN_W     = 5;
	localparam int WLEN_W     = 5;
	localparam int K_MAX      = 16;
	localparam int SEEN_W     = 6;
	localparam int SEEN_MAX   = (1 << SEEN_W) - 1;
	localparam int THR_W      = $clog2(K_MAX + MAX_WINDOW + SEEN_MAX + 1);
	localparam int GRP        = 4;
	localparam int NGRP       = (MAX_WINDOW + GRP - 1) / GRP;
	localparam int QDEPTH     = 8;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int QCNT_W     = $clog2(QDEPTH + 1);
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = ((HASH_BITS + CNT_W + 7) / 8) * 8;

	localparam logic [CFG_IDX_W-1:0] CFG_KMER_LEN   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 1'b1;

	localparam logic [KLEN_W-1:0] KLEN_RESET = 5'd5;
	localparam logic [WLEN_W-1:0] WLEN_RESET = 5'd3;

	typedef logic [HASH_BITS-1:0] hash_t;
	typedef logic [CNT_W-1:0]     count_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_UPDATE
	} back_state_t;

endpackage

// ===== sv/kmer_minimizer_counter_core.sv =====
// K-mer minimizer counter top level: front end, hash queue and count table.
// The core takes one base per transfer and, once a full window of k-mer hashes exists
// in the current sequence, emits the window minimum with its updated, saturating count.
// The front end takes a base every cycle while the hash queue has room; the count stage
// does a registered table read, then the write-back, per emitted minimizer and pops no
// new one until the write-back, so with a result per base it sets the sustained rate.
// A result passes the tree registers, the queue, the table read and the output register.
// After reset the 2^20 table entries are cleared one entry a cycle, taking no base; the
// user must write configuration only while no base is in flight; the block does not check.
module kmer_minimizer_counter_core
	import kmc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [1:0] base_code, rest zero
	input  logic                  s_axis_tuser,  // seq_start
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata   // [19:0] minimizer, [51:20] occurrences
);

	logic              hold;
	logic [QCNT_W-1:0] q_count;
	logic              push;
	hash_t             push_data;
	logic              pop;
	hash_t             head;
	logic              empty;
	hash_t             minimizer;
	count_t            occurrences;

	kmc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_axis_tvalid),
		.base_code (s_axis_tdata[1:0]),
		.seq_start (s_axis_tuser),
		.in_ready  (s_axis_tready),
		.hold      (hold),
		.q_count   (q_count),
		.push      (push),
		.push_data (push_data)
	);

	kmc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.empty     (empty),
		.count     (q_count)
	);

	kmc_count u_count (
		.clk         (clk),
		.arst_n      (arst_n),
		.empty       (empty),
		.head        (head),
		.pop         (pop),
		.busy        (hold),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.minimizer   (minimizer),
		.occurrences (occurrences)
	);

	assign m_axis_tdata = {(OUT_DATA_W - HASH_BITS - CNT_W)'(0), occurrences, minimizer};

endmodule

// ===== sv/kmc_fifo.sv =====
// Short queue of minimizer hashes between the front and the count stage.
module kmc_fifo
	import kmc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  hash_t             push_data,
	input  logic              pop,
	output hash_t             head,
	output logic              empty,
	output logic [QCNT_W-1:0] count
);

	hash_t             buf_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign head  = buf_q[rd_q];
	assign empty = (cnt_q == '0);
	assign count = cnt_q;

endmodule

// ===== sv/kmc_front.sv =====
// Front end: configuration, k-mer shift, hash window and registered minimum tree.
module kmc_front
	import kmc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic [1:0]            base_code,
	input  logic                  seq_start,
	output logic                  in_ready,
	input  logic                  hold,
	input  logic [QCNT_W-1:0]     q_count,
	output logic                  push,
	output hash_t                 push_data
);

	logic [KLEN_W-1:0] kmer_len_q;
	logic [WLEN_W-1:0] window_len_q;
	hash_t             kmer_q;
	logic [SEEN_W-1:0] seen_q;
	hash_t             win_q [MAX_WINDOW];
	logic              pend_q;
	hash_t             min_s1 [NGRP];
	logic              v_s1;
	hash_t             min_s2;
	logic              v_s2;

	logic [KLEN_W-1:0] k_eff;
	logic [THR_W-1:0]  w_eff;
	logic [THR_W-1:0]  wl_ext;
	logic              accept;
	hash_t             shift_base;
	logic [SEEN_W-1:0] seen_base;
	hash_t             shift_nx;
	logic [SEEN_W-1:0] seen_nx;
	hash_t             hmask;
	hash_t             hash;
	logic              hash_ok;
	logic              emit;
	hash_t             grp_min [NGRP];
	hash_t             all_min;
	logic [QCNT_W:0]   pending;

	always_comb begin
		if (kmer_len_q == '0) begin
			k_eff = KLEN_W'(1);
		end else if (kmer_len_q > KLEN_W'(K_MAX)) begin
			k_eff = KLEN_W'(K_MAX);
		end else begin
			k_eff = kmer_len_q;
		end
		wl_ext = THR_W'(window_len_q);
		if (wl_ext == '0) begin
			w_eff = THR_W'(1);
		end else if (wl_ext > THR_W'(MAX_WINDOW)) begin
			w_eff = THR_W'(MAX_WINDOW);
		end else begin
			w_eff = wl_ext;
		end
	end

	assign accept     = in_valid && in_ready;
	assign shift_base = seq_start ? '0 : kmer_q;
	assign seen_base  = seq_start ? '0 : seen_q;
	assign shift_nx   = {shift_base[HASH_BITS-3:0], base_code};
	assign seen_nx    = (seen_base == SEEN_W'(SEEN_MAX)) ? seen_base : seen_base + 1'b1;

	always_comb begin
		for (int j = 0; j < HASH_BITS; j++) begin
			hmask[j] = (j < 2 * int'(k_eff));
		end
	end

	assign hash    = shift_nx & hmask;
	assign hash_ok = THR_W'(seen_nx) >= THR_W'(k_eff);
	assign emit    = THR_W'(seen_nx) >= (THR_W'(k_eff) + w_eff - THR_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_len_q   <= KLEN_RESET;
			window_len_q <= WLEN_RESET;
			kmer_q       <= '0;
			seen_q       <= '0;
			pend_q       <= 1'b0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_KMER_LEN:   kmer_len_q   <= cfg_data;
					CFG_WINDOW_LEN: window_len_q <= cfg_data;
					default:        kmer_len_q   <= kmer_len_q;
				endcase
			end
			if (accept) begin
				kmer_q <= shift_nx;
				seen_q <= seen_nx;
			end
			pend_q <= accept && emit;
			v_s1   <= pend_q;
			v_s2   <= v_s1;
		end
	end

	// Window shift, newest at index 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_WINDOW; i++) begin
				win_q[i] <= '0;
			end
		end else if (accept && hash_ok) begin
			win_q[0] <= hash;
			for (int i = 1; i < MAX_WINDOW; i++) begin
				win_q[i] <= win_q[i-1];
			end
		end
	end

	// First tree level: minimum within groups, entries past the window read as all ones
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_min[g] = '1;
			for (int e = 0; e < GRP; e++) begin
				if ((g * GRP + e) < MAX_WINDOW) begin
					if (((g * GRP + e) < int'(w_eff)) && (win_q[g * GRP + e] < grp_min[g])) begin
						grp_min[g] = win_q[g * GRP + e];
					end
				end
			end
		end
	end

	always_comb begin
		all_min = '1;
		for (int g = 0; g < NGRP; g++) begin
			if (min_s1[g] < all_min) begin
				all_min = min_s1[g];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < NGRP; g++) begin
			min_s1[g] <= grp_min[g];
		end
		min_s2 <= all_min;
	end

	// Credit check: every result in flight already has a queue slot
	assign pending   = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(pend_q) + (QCNT_W+1)'(v_s1)
		+ (QCNT_W+1)'(v_s2);
	assign in_ready  = !hold && (pending < (QCNT_W+1)'(QDEPTH));
	assign push      = v_s2;
	assign push_data = min_s2;

endmodule

// ===== sv/kmc_count.sv =====
// Back end: count table with clearing pass, read-modify-write and output register.
module kmc_count
	import kmc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   empty,
	input  hash_t  head,
	output logic   pop,
	output logic   busy,
	output logic   out_valid,
	input  logic   out_ready,
	output hash_t  minimizer,
	output count_t occurrences
);

	localparam int TABLE_SIZE = 1 << HASH_BITS;

	count_t      table_mem [TABLE_SIZE];
	back_state_t state_q;
	back_state_t state_nx;
	hash_t       clr_q;
	hash_t       addr_q;
	count_t      rdata_q;
	logic        out_valid_q;
	hash_t       out_min_q;
	count_t      out_cnt_q;

	logic        we;
	hash_t       waddr;
	count_t      wdata;
	count_t      inc;
	logic        load;

	assign inc = (rdata_q == '1) ? rdata_q : rdata_q + 1'b1;

	always_comb begin
		state_nx = state_q;
		we       = 1'b0;
		waddr    = addr_q;
		wdata    = inc;
		pop      = 1'b0;
		load     = 1'b0;
		case (state_q)
			BK_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '0;
				if (clr_q == '1) begin
					state_nx = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (!empty && (!out_valid_q || out_ready)) begin
					pop      = 1'b1;
					state_nx = BK_UPDATE;
				end
			end
			BK_UPDATE: begin
				we       = 1'b1;
				load     = 1'b1;
				state_nx = BK_IDLE;
			end
			default: state_nx = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			table_mem[waddr] <= wdata;
		end
		rdata_q <= table_mem[head];
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			addr_q <= head;
		end
		if (load) begin
			out_min_q <= addr_q;
			out_cnt_q <= inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == BK_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign busy        = (state_q == BK_CLEAR);
	assign out_valid   = out_valid_q;
	assign minimizer   = out_min_q;
	assign occurrences = out_cnt_q;

endmodule
